// File: rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, codes and frame tables for the gamepad serial poll master.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned HalfW     = 8;
  localparam int unsigned ByteCntW  = 4;
  localparam int unsigned BitCntW   = 3;
  localparam logic [HalfW-1:0] HalfReset = 8'd10;
  localparam logic [3:0] ModeAnalog = 4'h7;
  localparam logic [ByteCntW-1:0] ShortLen = 4'd5;
  localparam logic [ByteCntW-1:0] LongLen  = 4'd9;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE = 2'd0,
    CMD_POLL = 2'd1,
    CMD_CONF = 2'd2
  } gsp_cmd_e;

  // sequencer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_GAP  = 4'b1000
  } gsp_phase_e;

  typedef enum logic [1:0] {
    FR_ENTER = 2'd0,
    FR_MODE  = 2'd1,
    FR_EXIT  = 2'd2,
    FR_POLL  = 2'd3
  } gsp_frame_e;

  // poll frame byte positions that are kept
  localparam logic [ByteCntW-1:0] IdxMode  = 4'd1;
  localparam logic [ByteCntW-1:0] IdxBtnLo = 4'd3;
  localparam logic [ByteCntW-1:0] IdxBtnHi = 4'd4;
  localparam logic [ByteCntW-1:0] IdxStk0  = 4'd5;
  localparam logic [ByteCntW-1:0] IdxStk1  = 4'd6;
  localparam logic [ByteCntW-1:0] IdxStk2  = 4'd7;
  localparam logic [ByteCntW-1:0] IdxStk3  = 4'd8;

  // packed with clock_line at bit 0
  typedef struct packed {
    logic [31:0] sticks;
    logic [15:0] buttons_changed;
    logic [15:0] buttons;
    logic [7:0]  mode_id;
    logic        busy_res;
    logic        attention_line;
    logic        command_line;
    logic        clock_line;
  } gsp_result_t;

  localparam int unsigned ResW  = $bits(gsp_result_t);
  localparam int unsigned OutDW = ((ResW + 7) / 8) * 8;

  localparam logic [7:0] EnterFrame [5] = '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00};
  localparam logic [7:0] ModeFrame  [9] = '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03,
                                            8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] ExitFrame  [9] = '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A,
                                            8'h5A, 8'h5A, 8'h5A, 8'h5A};

  function automatic logic [ByteCntW-1:0] frame_len(gsp_frame_e fr);
    return (fr == FR_ENTER) ? ShortLen : LongLen;
  endfunction

  function automatic logic [7:0] frame_byte(gsp_frame_e fr, logic [ByteCntW-1:0] idx);
    logic [7:0] b;
    b = 8'hFF;
    if (idx < frame_len(fr)) begin
      case (fr)
        FR_ENTER: b = EnterFrame[idx[2:0]];
        FR_MODE:  b = ModeFrame[idx];
        FR_EXIT:  b = ExitFrame[idx];
        FR_POLL:  b = (idx == 4'd0) ? 8'h01 : ((idx == 4'd1) ? 8'h42 : 8'hFF);
        default:  b = 8'hFF;
      endcase
    end
    return b;
  endfunction

endpackage

// File: rtl/gsp_cfg.sv
// ----------------------------------------------------------------------------
// gsp_cfg
// APB register block: half-period tick count.
// ----------------------------------------------------------------------------
module gsp_cfg import gsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [HalfW-1:0] half_o
);

  logic [HalfW-1:0] half_q, half_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == 1'b0);

  always_comb begin
    half_d = half_q;
    if (wr_en) begin
      half_d = pwdata[HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfReset;
    end else begin
      half_q <= half_d;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-HalfW){1'b0}}, half_q} : 32'd0;
  assign half_o = half_q;

endmodule

// File: rtl/gsp_seq.sv
// ----------------------------------------------------------------------------
// gsp_seq
// Frame sequencer: one tick per step, drives the link pins and keeps the
// captured poll results.
// ----------------------------------------------------------------------------
module gsp_seq import gsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic             din_i,
  input  logic [HalfW-1:0] half_i,
  output gsp_result_t      res_o,
  output logic             done_o
);

  gsp_phase_e          ph_q, ph_d;
  gsp_frame_e          fr_q, fr_d;
  logic [ByteCntW-1:0] byte_q, byte_d;
  logic [BitCntW-1:0]  bit_q, bit_d;
  logic [HalfW-1:0]    dly_q, dly_d;
  logic [7:0]          rx_q, rx_d;
  logic                conf_q, conf_d;
  logic [7:0]          mode_q, mode_d;
  logic [15:0]         btn_q, btn_d;
  logic [15:0]         prev_q, prev_d;
  logic [31:0]         stk_q, stk_d;

  logic [HalfW-1:0]    limit;
  logic [HalfW-1:0]    dly_inc;
  logic [ByteCntW-1:0] byte_inc;
  logic [7:0]          ob;
  logic                clk_l, cmd_l, att_l, busy, done;

  assign limit = (half_i == '0) ? HalfW'(1) : half_i;

  always_comb begin
    ph_d   = ph_q;
    fr_d   = fr_q;
    byte_d = byte_q;
    bit_d  = bit_q;
    dly_d  = dly_q;
    rx_d   = rx_q;
    conf_d = conf_q;
    mode_d = mode_q;
    btn_d  = btn_q;
    prev_d = prev_q;
    stk_d  = stk_q;
    clk_l  = 1'b1;
    cmd_l  = 1'b1;
    att_l  = 1'b1;
    busy   = 1'b0;
    done   = 1'b0;
    ob     = 8'hFF;
    dly_inc  = '0;
    byte_inc = '0;

    // a command taken in idle makes this tick the first clock-low tick
    if (ph_q == PH_IDLE && (cmd_i == CMD_POLL || cmd_i == CMD_CONF)) begin
      conf_d = (cmd_i == CMD_CONF);
      fr_d   = (cmd_i == CMD_CONF) ? FR_ENTER : FR_POLL;
      byte_d = '0;
      bit_d  = '0;
      dly_d  = '0;
      ph_d   = PH_LOW;
    end

    case (ph_d)
      PH_LOW, PH_HIGH: begin
        ob      = frame_byte(fr_d, byte_d);
        busy    = 1'b1;
        att_l   = 1'b0;
        cmd_l   = ob[bit_d];
        clk_l   = (ph_d == PH_HIGH);
        dly_inc = dly_d + HalfW'(1);
        dly_d   = dly_inc;
        if (dly_inc >= limit) begin
          dly_d = '0;
          if (ph_d == PH_LOW) begin
            rx_d[bit_d] = din_i;
            ph_d        = PH_HIGH;
          end else if (bit_d != 3'd7) begin
            bit_d = bit_d + 3'd1;
            ph_d  = PH_LOW;
          end else begin
            if (fr_d == FR_POLL) begin
              case (byte_d)
                IdxMode:  mode_d = rx_d;
                IdxBtnLo: begin
                  prev_d = btn_d;
                  btn_d  = {btn_d[15:8], ~rx_d};
                end
                IdxBtnHi: btn_d = {~rx_d, btn_d[7:0]};
                IdxStk0:  stk_d = {stk_d[31:8], rx_d};
                IdxStk1:  stk_d = {stk_d[31:16], rx_d, stk_d[7:0]};
                IdxStk2:  stk_d = {stk_d[31:24], rx_d, stk_d[15:0]};
                IdxStk3:  stk_d = {rx_d, stk_d[23:0]};
                default:  ;
              endcase
            end
            bit_d    = '0;
            byte_inc = byte_d + ByteCntW'(1);
            byte_d   = byte_inc;
            if (byte_inc >= frame_len(fr_d)) begin
              done = (fr_d == FR_POLL);
              ph_d = PH_GAP;
            end else begin
              ph_d = PH_LOW;
            end
          end
        end
      end
      PH_GAP: begin
        busy    = 1'b1;
        dly_inc = dly_d + HalfW'(1);
        dly_d   = dly_inc;
        if (dly_inc >= limit) begin
          dly_d = '0;
          if (fr_d != FR_POLL) begin
            fr_d   = gsp_frame_e'(fr_d + 2'd1);
            byte_d = '0;
            bit_d  = '0;
            ph_d   = PH_LOW;
          end else if (conf_d && mode_d[7:4] != ModeAnalog) begin
            // mode not yet analog: run the whole configure sequence again
            fr_d   = FR_ENTER;
            byte_d = '0;
            bit_d  = '0;
            ph_d   = PH_LOW;
          end else begin
            conf_d = 1'b0;
            ph_d   = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      fr_q   <= FR_ENTER;
      byte_q <= '0;
      bit_q  <= '0;
      dly_q  <= '0;
      rx_q   <= '0;
      conf_q <= 1'b0;
      mode_q <= '0;
      btn_q  <= '0;
      prev_q <= '0;
      stk_q  <= '0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      fr_q   <= fr_d;
      byte_q <= byte_d;
      bit_q  <= bit_d;
      dly_q  <= dly_d;
      rx_q   <= rx_d;
      conf_q <= conf_d;
      mode_q <= mode_d;
      btn_q  <= btn_d;
      prev_q <= prev_d;
      stk_q  <= stk_d;
    end
  end

  always_comb begin
    res_o.clock_line      = clk_l;
    res_o.command_line    = cmd_l;
    res_o.attention_line  = att_l;
    res_o.busy_res        = busy;
    res_o.mode_id         = mode_d;
    res_o.buttons         = btn_d;
    res_o.buttons_changed = prev_d ^ btn_d;
    res_o.sticks          = stk_d;
  end

  assign done_o = done;

endmodule

// File: rtl/gamepad_serial_poll_master.sv
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master
// Tick-driven bit-level master for a gamepad serial link.
// ----------------------------------------------------------------------------
// Each input word is one tick; each tick yields exactly one output word with
// the pin levels and the latest poll results. Throughput is one word per
// cycle while the output side is not stalling: the sequencer step for a tick
// is combinational between the input register and the output register, and a
// word passes through both registers on its way out. frame_done rides
// on tlast. Write half_period_ticks only while the link is idle.
module gamepad_serial_poll_master import gsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB config
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // tick input
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [1:0] command, [2] data_line
  // result output
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutDW-1:0] m_axis_tdata,  // clock_line, command_line,
                                          // attention_line, busy_res,
                                          // mode_id[7:0], buttons[15:0],
                                          // buttons_changed[15:0], sticks[31:0]
  output logic             m_axis_tlast   // frame_done
);

  logic [HalfW-1:0] half;
  logic             in_vld_q, in_vld_d;
  logic [CmdW-1:0]  in_cmd_q;
  logic             in_din_q;
  logic             out_vld_q, out_vld_d;
  gsp_result_t      out_res_q;
  logic             out_done_q;
  gsp_result_t      res;
  logic             done;
  logic             out_free, advance, in_acc;

  gsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .half_o  (half)
  );

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign advance       = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | out_free;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  gsp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (in_cmd_q),
    .din_i  (in_din_q),
    .half_i (half),
    .res_o  (res),
    .done_o (done)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_cmd_q <= s_axis_tdata[CmdW-1:0];
      in_din_q <= s_axis_tdata[CmdW];
    end
    if (advance) begin
      out_res_q  <= res;
      out_done_q <= done;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDW-ResW){1'b0}}, out_res_q};
  assign m_axis_tlast  = out_done_q;

endmodule

// File: rtl/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level assertions for the gamepad serial poll master.
// ----------------------------------------------------------------------------
module gsp_checker import gsp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [7:0]       s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutDW-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // attention only drops inside a busy sequence
  a_att_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[3])
    else $error("attention low outside a sequence");

  // idle link rests with clock and command high, attention released
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |->
      m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[2] && !m_axis_tlast)
    else $error("pins not at rest while idle");

  // poll completes on the last clock-high tick of the frame
  a_done_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[3] && !m_axis_tdata[2] && m_axis_tdata[0])
    else $error("frame done outside a clock-high frame tick");

endmodule

bind gamepad_serial_poll_master gsp_checker u_gsp_checker (.*);
